@@ design/sfl_pkg.sv @@
// shared types and constants of the stereo flanger
// used by sfl_sweep, sfl_lane and stereo_flanger_unit; depends on nothing
`default_nettype none

package sfl_pkg;

  localparam int SAMPLE_WIDTH  = 16;
  localparam int DELAY_DEPTH   = 1024;
  localparam int COUNTER_WIDTH = 20;

  localparam int ADDR_W     = $clog2(DELAY_DEPTH);
  localparam int HALF_DEPTH = DELAY_DEPTH / 2;
  localparam int BIT_W      = $clog2(COUNTER_WIDTH);

  // q16 gains
  localparam int Q_FRAC = 16;
  localparam int GAIN_W = Q_FRAC + 1;
  localparam logic [GAIN_W-1:0] Q16_ONE = GAIN_W'(1 << Q_FRAC);
  localparam int PROD_W = SAMPLE_WIDTH + GAIN_W + 1;

  // configuration
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = COUNTER_WIDTH;
  localparam logic [CFG_INDEX_W-1:0] CFG_PERIOD   = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_INTERVAL = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_WET_GAIN = 2'd2;

  localparam logic [COUNTER_WIDTH-1:0] PERIOD_RESET   = COUNTER_WIDTH'(44100);
  localparam logic [COUNTER_WIDTH-1:0] INTERVAL_RESET = COUNTER_WIDTH'(100);
  localparam logic [GAIN_W-1:0]        WET_RESET      = GAIN_W'(32768);

  // output queue
  localparam int OUT_DEPTH = 8;
  localparam int OUT_AW    = $clog2(OUT_DEPTH);

  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] left_sample;
    logic signed [SAMPLE_WIDTH-1:0] right_sample;
  } sample_t;

  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] left_out;
    logic signed [SAMPLE_WIDTH-1:0] right_out;
  } mix_t;

  // delay line addressing handed from the sweep to both lanes
  typedef struct packed {
    logic [ADDR_W-1:0] wr_ptr;
    logic [ADDR_W-1:0] centre_idx;
    logic [ADDR_W-1:0] wet_idx;
    logic              centre_ok;
    logic              wet_ok;
  } tap_addr_t;

endpackage

`default_nettype wire

@@ design/sfl_sweep.sv @@
// triangle sweep of the wet tap offset, write pointer and tap addressing
// depends on sfl_pkg
`default_nettype none

module sfl_sweep (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                advance,
  input  wire logic                                recalc,
  input  wire logic [sfl_pkg::COUNTER_WIDTH-1:0]   period,
  input  wire logic [sfl_pkg::COUNTER_WIDTH-1:0]   interval,
  output sfl_pkg::tap_addr_t                       taps,
  output logic                                     busy
);

  localparam int AW = sfl_pkg::ADDR_W;
  localparam int CW = sfl_pkg::COUNTER_WIDTH;
  localparam logic [AW-1:0] HALF       = AW'(sfl_pkg::HALF_DEPTH);
  localparam logic [AW-1:0] OFFSET_MAX = AW'(sfl_pkg::HALF_DEPTH - 1);
  localparam logic [AW-1:0] OFFSET_MIN = AW'(sfl_pkg::HALF_DEPTH);
  localparam logic [AW-1:0] PTR_LAST   = AW'(sfl_pkg::DELAY_DEPTH - 1);

  typedef enum logic [1:0] {
    PH_HALF_RISE = 2'd0,
    PH_RISE      = 2'd1,
    PH_FALL      = 2'd2
  } phase_t;

  typedef enum logic {
    ST_RUN,
    ST_CALC
  } state_t;

  state_t                         state;
  phase_t                         phase;
  logic [AW-1:0]                  wr_ptr;
  logic                           full;
  logic [AW-1:0]                  tap_offset;
  logic [CW-1:0]                  sweep_count;
  logic [CW-1:0]                  rem_step;
  logic [CW-1:0]                  rem_limit;
  logic [sfl_pkg::BIT_W-1:0]      bit_idx;

  logic [CW-1:0] interval_eff;
  logic [CW-1:0] limit_raw;
  logic [CW-1:0] limit_eff;
  logic [CW-1:0] count_inc;
  logic          wrapped;
  logic          step_hit;
  logic          limit_hit;
  logic          rising;
  logic [CW:0]   trial_step;
  logic [CW:0]   trial_limit;
  logic [CW-1:0] calc_step;
  logic [CW-1:0] calc_limit;
  logic [AW-1:0] centre_idx;
  logic [AW-1:0] wet_idx;

  // zero divisors act as one
  assign interval_eff = (interval == '0) ? CW'(1) : interval;
  assign limit_raw    = (phase == PH_HALF_RISE) ? (period >> 1) : period;
  assign limit_eff    = (limit_raw == '0) ? CW'(1) : limit_raw;

  // rem_* track sweep_count modulo each divisor
  assign count_inc = sweep_count + CW'(1);
  assign wrapped   = (count_inc == '0);
  assign step_hit  = wrapped || (({1'b0, rem_step} + (CW+1)'(1)) == {1'b0, interval_eff});
  assign limit_hit = wrapped || (({1'b0, rem_limit} + (CW+1)'(1)) == {1'b0, limit_eff});
  assign rising    = (phase == PH_HALF_RISE) || (phase == PH_RISE);

  // one restoring remainder step per cycle after a divisor change
  assign trial_step  = {rem_step, sweep_count[bit_idx]};
  assign trial_limit = {rem_limit, sweep_count[bit_idx]};
  assign calc_step   = (trial_step >= {1'b0, interval_eff}) ?
                       CW'(trial_step - {1'b0, interval_eff}) : CW'(trial_step);
  assign calc_limit  = (trial_limit >= {1'b0, limit_eff}) ?
                       CW'(trial_limit - {1'b0, limit_eff}) : CW'(trial_limit);

  // entries not yet written since reset read as zero
  assign centre_idx = wr_ptr - HALF;
  assign wet_idx    = centre_idx + tap_offset;

  assign taps.wr_ptr     = wr_ptr;
  assign taps.centre_idx = centre_idx;
  assign taps.wet_idx    = wet_idx;
  assign taps.centre_ok  = full || (centre_idx < wr_ptr);
  assign taps.wet_ok     = full || (wet_idx < wr_ptr);
  assign busy            = (state == ST_CALC);

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_RUN;
      phase       <= PH_HALF_RISE;
      wr_ptr      <= '0;
      full        <= 1'b0;
      tap_offset  <= '0;
      sweep_count <= '0;
      rem_step    <= '0;
      rem_limit   <= '0;
      bit_idx     <= '0;
    end else if (recalc) begin
      state     <= ST_CALC;
      bit_idx   <= sfl_pkg::BIT_W'(CW - 1);
      rem_step  <= '0;
      rem_limit <= '0;
    end else begin
      unique case (state)
        ST_CALC: begin
          rem_step  <= calc_step;
          rem_limit <= calc_limit;
          if (bit_idx == '0) begin
            state <= ST_RUN;
          end else begin
            bit_idx <= bit_idx - sfl_pkg::BIT_W'(1);
          end
        end
        ST_RUN: begin
          if (advance) begin
            wr_ptr <= wr_ptr + AW'(1);
            if (wr_ptr == PTR_LAST) begin
              full <= 1'b1;
            end
            if (step_hit) begin
              if (rising) begin
                if (tap_offset != OFFSET_MAX) begin
                  tap_offset <= tap_offset + AW'(1);
                end
              end else if (tap_offset != OFFSET_MIN) begin
                tap_offset <= tap_offset - AW'(1);
              end
            end
            if (limit_hit) begin
              sweep_count <= '0;
              rem_step    <= '0;
              rem_limit   <= '0;
              unique case (phase) inside
                PH_HALF_RISE, PH_RISE: phase <= PH_FALL;
                default:               phase <= PH_RISE;
              endcase
            end else begin
              sweep_count <= count_inc;
              rem_step    <= step_hit ? '0 : rem_step + CW'(1);
              rem_limit   <= rem_limit + CW'(1);
            end
          end
        end
        default: state <= ST_RUN;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ design/sfl_lane.sv @@
// one channel lane: delay line memory with two registered taps and q16 mix
// depends on sfl_pkg
`default_nettype none

module sfl_lane (
  input  wire logic                                      clk,
  input  wire sfl_pkg::tap_addr_t                        taps,
  input  wire logic                                      wr_en,
  input  wire logic signed [sfl_pkg::SAMPLE_WIDTH-1:0]   wr_data,
  input  wire logic [sfl_pkg::GAIN_W-1:0]                wet,
  input  wire logic [sfl_pkg::GAIN_W-1:0]                dry,
  output logic signed [sfl_pkg::SAMPLE_WIDTH-1:0]        result
);

  localparam int SW = sfl_pkg::SAMPLE_WIDTH;
  localparam int PW = sfl_pkg::PROD_W;
  localparam int QF = sfl_pkg::Q_FRAC;

  logic signed [SW-1:0] delay_mem [sfl_pkg::DELAY_DEPTH];
  logic signed [SW-1:0] rd_centre;
  logic signed [SW-1:0] rd_wet;
  logic                 centre_ok;
  logic                 wet_ok;
  logic signed [SW-1:0] centre_v;
  logic signed [SW-1:0] wet_v;
  logic signed [PW-1:0] prod_centre;
  logic signed [PW-1:0] prod_wet;
  logic signed [PW:0]   rounded;

  // reads see the old word when the write hits the same address
  always_ff @(posedge clk) begin
    if (wr_en) begin
      delay_mem[taps.wr_ptr] <= wr_data;
    end
    rd_centre <= delay_mem[taps.centre_idx];
    rd_wet    <= delay_mem[taps.wet_idx];
    centre_ok <= taps.centre_ok;
    wet_ok    <= taps.wet_ok;
  end

  assign centre_v = centre_ok ? rd_centre : '0;
  assign wet_v    = wet_ok ? rd_wet : '0;

  always_ff @(posedge clk) begin
    prod_centre <= PW'($signed({1'b0, dry}) * centre_v);
    prod_wet    <= PW'($signed({1'b0, wet}) * wet_v);
  end

  // round half up, then floor
  assign rounded = (PW+1)'(prod_centre) + (PW+1)'(prod_wet) + (PW+1)'(1 << (QF - 1));

  always_ff @(posedge clk) begin
    result <= rounded[QF+SW-1:QF];
  end

endmodule

`default_nettype wire

@@ design/stereo_flanger_unit.sv @@
// top level of the stereo flanger: config registers, lanes, output queue
// depends on sfl_pkg, sfl_sweep and sfl_lane
`default_nettype none

// stereo flanger
// sample channel: one stereo pair per request (sample_valid/sample_ready);
// mix channel: one mixed pair per request (mix_valid/mix_ready)
// cfg channel: index 0 period_samples, 1 pitch_step_interval, 2 wet_gain;
// other indexes are ignored, cfg_ready is always high
// throughput: one pair per cycle while sample_ready is high, two lanes (left, right) run side by side
// path: from its sample request a result passes the registered memory read,
// the multiply stage, the rounding stage and the output queue before mix_valid
// writing period or interval recomputes the sweep counter remainders,
// one bit per cycle: sample_ready stays low until that pass is done
// reset: config returns to 44100/100/32768, sweep restarts at the half rise;
// delay lines read as zero until written (tracked by the write pointer and a
// wrap flag), so no clearing pass is needed
// receiver stall: results collect in an 8 entry queue; sample_ready drops
// once queued plus in flight results would overfill it
module stereo_flanger_unit (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 sample_valid,
  output logic                                      sample_ready,
  input  wire sfl_pkg::sample_t                     sample,
  output logic                                      mix_valid,
  input  wire logic                                 mix_ready,
  output sfl_pkg::mix_t                             mix,
  input  wire logic                                 cfg_valid,
  output logic                                      cfg_ready,
  input  wire logic [sfl_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  wire logic [sfl_pkg::CFG_DATA_W-1:0]       cfg_data
);

  localparam int CW  = sfl_pkg::COUNTER_WIDTH;
  localparam int GW  = sfl_pkg::GAIN_W;
  localparam int QAW = sfl_pkg::OUT_AW;

  // configuration registers
  logic [CW-1:0] period_samples;
  logic [CW-1:0] pitch_step_interval;
  logic [GW-1:0] wet_gain;
  logic          cfg_write;
  logic          recalc;

  // lane feed
  sfl_pkg::tap_addr_t taps;
  logic               sweep_busy;
  logic               accept;
  logic [GW-1:0]      wet_eff;
  logic [GW-1:0]      dry_eff;
  sfl_pkg::mix_t      lane_result;

  // in flight markers, one per lane stage
  logic stage1_valid;
  logic stage2_valid;
  logic stage3_valid;

  // output queue
  sfl_pkg::mix_t  out_queue [sfl_pkg::OUT_DEPTH];
  logic [QAW-1:0] q_wr_ptr;
  logic [QAW-1:0] q_rd_ptr;
  logic [QAW:0]   q_count;
  logic [QAW:0]   occupancy;
  logic           q_push;
  logic           q_pop;

  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      period_samples      <= sfl_pkg::PERIOD_RESET;
      pitch_step_interval <= sfl_pkg::INTERVAL_RESET;
      wet_gain            <= sfl_pkg::WET_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        sfl_pkg::CFG_PERIOD:   period_samples      <= cfg_data;
        sfl_pkg::CFG_INTERVAL: pitch_step_interval <= cfg_data;
        sfl_pkg::CFG_WET_GAIN: wet_gain            <= GW'(cfg_data);
        default: ;
      endcase
    end
  end

  // the sweep starts its remainder pass the cycle after the new divisor lands
  always_ff @(posedge clk) begin
    if (rst) begin
      recalc <= 1'b0;
    end else begin
      recalc <= cfg_write &&
                ((cfg_index == sfl_pkg::CFG_PERIOD) || (cfg_index == sfl_pkg::CFG_INTERVAL));
    end
  end

  // wet above one is clamped, dry is its complement
  assign wet_eff = (wet_gain > sfl_pkg::Q16_ONE) ? sfl_pkg::Q16_ONE : wet_gain;
  assign dry_eff = sfl_pkg::Q16_ONE - wet_eff;

  // occupancy counts queued results plus those still in the lanes
  assign occupancy = q_count + (QAW+1)'(stage1_valid) + (QAW+1)'(stage2_valid)
                   + (QAW+1)'(stage3_valid);
  assign sample_ready = !sweep_busy && !recalc
                      && (occupancy < (QAW+1)'(sfl_pkg::OUT_DEPTH));
  assign accept = sample_valid && sample_ready;

  sfl_sweep u_sweep (
    .clk      (clk),
    .rst      (rst),
    .advance  (accept),
    .recalc   (recalc),
    .period   (period_samples),
    .interval (pitch_step_interval),
    .taps     (taps),
    .busy     (sweep_busy)
  );

  sfl_lane u_lane_left (
    .clk     (clk),
    .taps    (taps),
    .wr_en   (accept),
    .wr_data (sample.left_sample),
    .wet     (wet_eff),
    .dry     (dry_eff),
    .result  (lane_result.left_out)
  );

  sfl_lane u_lane_right (
    .clk     (clk),
    .taps    (taps),
    .wr_en   (accept),
    .wr_data (sample.right_sample),
    .wet     (wet_eff),
    .dry     (dry_eff),
    .result  (lane_result.right_out)
  );

  // lanes run in lockstep, so one marker chain covers both
  always_ff @(posedge clk) begin
    if (rst) begin
      stage1_valid <= 1'b0;
      stage2_valid <= 1'b0;
      stage3_valid <= 1'b0;
    end else begin
      stage1_valid <= accept;
      stage2_valid <= stage1_valid;
      stage3_valid <= stage2_valid;
    end
  end

  // merge: both lane results enter the queue as one pair
  assign q_push    = stage3_valid;
  assign q_pop     = mix_valid && mix_ready;
  assign mix_valid = (q_count != '0);
  assign mix       = out_queue[q_rd_ptr];

  always_ff @(posedge clk) begin
    if (q_push) begin
      out_queue[q_wr_ptr] <= lane_result;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q_wr_ptr <= '0;
      q_rd_ptr <= '0;
      q_count  <= '0;
    end else begin
      if (q_push) begin
        q_wr_ptr <= q_wr_ptr + QAW'(1);
      end
      if (q_pop) begin
        q_rd_ptr <= q_rd_ptr + QAW'(1);
      end
      if (q_push && !q_pop) begin
        q_count <= q_count + (QAW+1)'(1);
      end else if (q_pop && !q_push) begin
        q_count <= q_count - (QAW+1)'(1);
      end
    end
  end

endmodule

`default_nettype wire

@@ bench/tb_stereo_flanger_unit.sv @@
// self-checking bench for stereo_flanger_unit: drives stereo pairs and register writes,
// predicts every mixed pair with its own delay lines and sweep, and compares field by field
// depends on sfl_pkg and stereo_flanger_unit
module tb_stereo_flanger_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SW = sfl_pkg::SAMPLE_WIDTH;
  localparam int CW = sfl_pkg::COUNTER_WIDTH;
  localparam int DW = sfl_pkg::CFG_DATA_W;
  localparam int IW = sfl_pkg::CFG_INDEX_W;
  localparam int AW = sfl_pkg::ADDR_W;
  localparam int HALF = sfl_pkg::HALF_DEPTH;

  // sweep direction codes of the predictor
  typedef enum logic [1:0] {HALF_RISE, RISING, FALLING, SPARE_PHASE} sweep_phase_t;

  // index past the register list, must be ignored by the block
  localparam logic [IW-1:0] CFG_UNUSED = 2'd3;
  // cycles with no request on any channel before the run is given up
  localparam int QUIET_LIMIT = 4000;
  // settle time after the last expected mix
  localparam int SETTLE_CYCLES = 10;
  // ring of predicted mixes, well above what the block can hold
  localparam int OWED_DEPTH = 64;

  // predictor of the flanger plus a ring of mixes still owed by the block
  class flanger_model;
    logic [CW-1:0]                   period;
    logic [CW-1:0]                   interval;
    logic [sfl_pkg::GAIN_W-1:0]      wet;
    logic signed [SW-1:0]            left_line[sfl_pkg::DELAY_DEPTH];
    logic signed [SW-1:0]            right_line[sfl_pkg::DELAY_DEPTH];
    logic [AW-1:0]                   wr_ptr;
    int                              offset;
    logic [CW-1:0]                   sweep_cnt;
    sweep_phase_t                    phase;
    sfl_pkg::mix_t                   owed[OWED_DEPTH];
    int                              owed_rd;
    int                              owed_wr;
    int                              owed_count;
    int                              errors;

    function new();
      period   = sfl_pkg::PERIOD_RESET;
      interval = sfl_pkg::INTERVAL_RESET;
      wet      = sfl_pkg::WET_RESET;
      foreach (left_line[i]) begin
        left_line[i]  = '0;
        right_line[i] = '0;
      end
      wr_ptr     = '0;
      offset     = 0;
      sweep_cnt  = '0;
      phase      = HALF_RISE;
      owed_rd    = 0;
      owed_wr    = 0;
      owed_count = 0;
      errors     = 0;
    endfunction

    function void write_reg(logic [IW-1:0] idx, logic [DW-1:0] data);
      case (idx)
        sfl_pkg::CFG_PERIOD:   period = data;
        sfl_pkg::CFG_INTERVAL: interval = data;
        sfl_pkg::CFG_WET_GAIN: wet = data[sfl_pkg::GAIN_W-1:0];
        default: ;
      endcase
    endfunction

    function bit rising();
      return phase == HALF_RISE || phase == RISING;
    endfunction

    // q16 convex mix, half added before the floor
    function logic signed [SW-1:0] blend(logic signed [SW-1:0] centre,
                                         logic signed [SW-1:0] tap,
                                         longint wet_q, longint dry_q);
      longint acc;
      acc = dry_q * centre + wet_q * tap;
      acc = (acc + 32768) >>> sfl_pkg::Q_FRAC;
      return acc[SW-1:0];
    endfunction

    function void take_pair(sfl_pkg::sample_t s);
      longint            wet_q;
      longint            dry_q;
      logic [AW-1:0]     centre_at;
      logic [AW-1:0]     tap_at;
      longint unsigned   step_every;
      longint unsigned   turn_at;
      sfl_pkg::mix_t     m;
      wet_q = (wet > sfl_pkg::Q16_ONE) ? sfl_pkg::Q16_ONE : wet;
      dry_q = sfl_pkg::Q16_ONE - wet_q;
      // taps read before this pair is stored; a delay of the full depth wraps to wr_ptr
      centre_at = wr_ptr - AW'(HALF);
      tap_at    = wr_ptr - AW'(HALF - offset);
      m.left_out  = blend(left_line[centre_at], left_line[tap_at], wet_q, dry_q);
      m.right_out = blend(right_line[centre_at], right_line[tap_at], wet_q, dry_q);
      owed[owed_wr] = m;
      owed_wr = (owed_wr + 1) % OWED_DEPTH;
      owed_count++;
      left_line[wr_ptr]  = s.left_sample;
      right_line[wr_ptr] = s.right_sample;
      wr_ptr    = wr_ptr + 1'b1;
      sweep_cnt = sweep_cnt + 1'b1;
      step_every = (interval == 0) ? 1 : interval;
      if (sweep_cnt % step_every == 0) begin
        if (rising()) begin
          if (offset < HALF - 1) offset++;
        end else if (offset > -HALF) begin
          offset--;
        end
      end
      turn_at = (phase == HALF_RISE) ? period / 2 : period;
      if (turn_at == 0) turn_at = 1;
      if (sweep_cnt % turn_at == 0) begin
        sweep_cnt = '0;
        phase = rising() ? FALLING : RISING;
      end
    endfunction

    function void check_mix(sfl_pkg::mix_t got);
      sfl_pkg::mix_t want;
      if (owed_count == 0) begin
        $display("%0t: mix with nothing pending: left %0d right %0d",
                 $time, got.left_out, got.right_out);
        errors++;
        return;
      end
      want = owed[owed_rd];
      owed_rd = (owed_rd + 1) % OWED_DEPTH;
      owed_count--;
      if (got.left_out !== want.left_out) begin
        $display("%0t: left_out expected %0d actual %0d", $time, want.left_out, got.left_out);
        errors++;
      end
      if (got.right_out !== want.right_out) begin
        $display("%0t: right_out expected %0d actual %0d", $time, want.right_out, got.right_out);
        errors++;
      end
    endfunction
  endclass

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     sample_valid = 1'b0;
  logic                     sample_ready;
  sfl_pkg::sample_t         sample = '0;
  logic                     mix_valid;
  logic                     mix_ready = 1'b0;
  sfl_pkg::mix_t            mix;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [IW-1:0]            cfg_index = '0;
  logic [DW-1:0]            cfg_data = '0;

  flanger_model flanger = new();
  bit sender_gaps = 1'b0;
  bit receiver_stalls = 1'b0;
  int idle_cycles = 0;

  always #1 clk = ~clk;

  stereo_flanger_unit uut (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .sample       (sample),
    .mix_valid    (mix_valid),
    .mix_ready    (mix_ready),
    .mix          (mix),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // watchdog: any request on any channel restarts the count
  always @(posedge clk) begin
    if ((sample_valid && sample_ready) || (mix_valid && mix_ready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= QUIET_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // mix side monitor, values taken as they stood at the edge
  always @(posedge clk) begin
    if (!rst && mix_valid && mix_ready) flanger.check_mix(mix);
  end

  // receiver: ready high except for random stall bursts while receiver_stalls is set
  initial begin
    forever begin
      @(posedge clk);
      if (receiver_stalls && $urandom_range(0, 5) == 0) begin
        mix_ready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
      end
      mix_ready <= 1'b1;
    end
  end

  // one sample request; valid stays high when the next pair follows right away
  task automatic send_pair(input sfl_pkg::sample_t s);
    if (sender_gaps && $urandom_range(0, 3) == 0) begin
      sample_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    sample_valid <= 1'b1;
    sample       <= s;
    @(posedge clk);
    while (!sample_ready) @(posedge clk);
    flanger.take_pair(s);
  endtask

  // writes period, interval and wet gain back to back, optionally the unused index too;
  // a period or interval write holds sample_ready low for a while, which the
  // next sample request simply waits out
  task automatic program_sweep(input logic [DW-1:0] per, input logic [DW-1:0] iv,
                               input logic [DW-1:0] gain, input bit poke_unused);
    logic [IW-1:0] regs[4];
    logic [DW-1:0] vals[4];
    int            last;
    regs[0] = sfl_pkg::CFG_PERIOD;
    regs[1] = sfl_pkg::CFG_INTERVAL;
    regs[2] = sfl_pkg::CFG_WET_GAIN;
    regs[3] = CFG_UNUSED;
    vals[0] = per;
    vals[1] = iv;
    vals[2] = gain;
    vals[3] = DW'($urandom());
    last = poke_unused ? 3 : 2;
    for (int k = 0; k <= last; k++) begin
      cfg_valid <= 1'b1;
      cfg_index <= regs[k];
      cfg_data  <= vals[k];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      flanger.write_reg(regs[k], vals[k]);
    end
    cfg_valid <= 1'b0;
  endtask

  // stop sending and wait for every owed mix
  task automatic drain_mixes();
    sample_valid <= 1'b0;
    while (flanger.owed_count != 0) @(posedge clk);
  endtask

  // mostly uniform levels, with full scale, zero and the unit steps mixed in
  function automatic logic signed [SW-1:0] pick_level();
    logic signed [SW-1:0] corners[5];
    corners = '{16'sh8000, 16'sh7fff, 16'sh0000, 16'shffff, 16'sh0001};
    if ($urandom_range(0, 7) == 0) return corners[$urandom_range(0, 4)];
    return SW'($urandom());
  endfunction

  // random pairs; idling is re-rolled every hundred pairs, none when quiet
  task automatic run_random(input int count, input bit quiet);
    sfl_pkg::sample_t s;
    for (int n = 0; n < count; n++) begin
      if (n % 100 == 0) begin
        sender_gaps     = !quiet && $urandom_range(0, 3) != 0;
        receiver_stalls = !quiet && $urandom_range(0, 3) != 0;
      end
      s.left_sample  = pick_level();
      s.right_sample = pick_level();
      send_pair(s);
    end
  endtask

  initial begin
    sfl_pkg::sample_t corner_pairs[12];
    sfl_pkg::sample_t s;
    corner_pairs = '{32'h7fff_8000, 32'h8000_7fff, 32'h0000_0000, 32'hffff_0001,
                     32'h7fff_7fff, 32'h8000_8000, 32'h0001_ffff, 32'h5555_aaaa,
                     32'haaaa_5555, 32'h8001_7ffe, 32'hffff_ffff, 32'h0100_ff00};
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // half rise with a zero half period and zero interval (both act as one),
    // wet gain above one, plus a write to the unused index
    program_sweep(20'd1, 20'd0, 20'hfffff, 1'b1);
    // full scale corners, first back to back, then with gaps and stalls
    foreach (corner_pairs[i]) send_pair(corner_pairs[i]);
    sender_gaps     = 1'b1;
    receiver_stalls = 1'b1;
    foreach (corner_pairs[i]) send_pair(corner_pairs[i]);
    drain_mixes();

    // period of two, dry only
    program_sweep(20'd2, 20'd1, 20'd0, 1'b0);
    run_random(40, 1'b0);
    drain_mixes();

    // long sweep, all wet: the offset runs into one of its limits and sits there
    program_sweep(20'd1030, 20'd1, 20'(sfl_pkg::Q16_ONE), 1'b1);
    run_random(520, 1'b0);
    drain_mixes();

    // short period so the direction flips quickly; stop once it points away
    // from the limit just reached, bouncing off the saturated offset on the way
    program_sweep(20'd2, 20'd1, 20'd65535, 1'b0);
    while (flanger.rising() == (flanger.offset > 0)) begin
      s.left_sample  = pick_level();
      s.right_sample = pick_level();
      send_pair(s);
    end
    drain_mixes();

    // longest period: one straight run across to the opposite limit
    program_sweep(20'hfffff, 20'd1, 20'($urandom_range(0, 65536)), 1'b0);
    run_random(1030, 1'b0);
    drain_mixes();

    // longest interval: the offset holds while the phase keeps turning
    program_sweep(20'd3, 20'hfffff, 20'd1, 1'b0);
    run_random(30, 1'b0);
    drain_mixes();

    // back to the power-on sweep, no idling on either side
    program_sweep(sfl_pkg::PERIOD_RESET, sfl_pkg::INTERVAL_RESET,
                  20'($urandom_range(0, 65536)), 1'b0);
    run_random(60, 1'b1);
    drain_mixes();

    // anything arriving now is unexpected and gets flagged by the monitor
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (flanger.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
